FILE: design/arm_pkg.sv
`timescale 1ns / 1ps

package arm_pkg;

  // Field widths.
  localparam int CODE_W   = 24;
  localparam int THR_W    = 23;
  localparam int REG16_W  = 16;
  localparam int RES_W    = 40;
  localparam int TIER_W   = 3;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Width of the full product D * M * scale, which stays below 2^60.
  localparam int PROD_W   = 60;
  localparam int QHI_W    = PROD_W - RES_W;
  localparam int SCALE_W  = 20;

  // Serial step counts.
  localparam int MUL_A_STEPS = REG16_W;
  localparam int MUL_B_STEPS = SCALE_W;
  localparam int DIV_STEPS   = RES_W;
  localparam int CNT_W       = 6;

  localparam logic [TIER_W-1:0] TOP_TIER = 3'd4;
  localparam logic [TIER_W-1:0] NOM_TIER = 3'd1;
  localparam logic [TIER_W-1:0] HALF_GAIN_TIER = 3'd2;
  localparam logic [RES_W-1:0]  RES_MAX  = {RES_W{1'b1}};

  // Status codes.
  localparam logic STATUS_RETRY = 1'b0;
  localparam logic STATUS_DONE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_MV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_OHMS = 3'd4;

  // Scale applied after the first product: 1e6 or 1e5 at the nominal tiers,
  // and sense gain times 1000 at the measured-current tiers.
  function automatic logic [SCALE_W-1:0] scale_of(input logic [TIER_W-1:0] tier);
    logic [SCALE_W-1:0] s;
    begin
      if (tier == 3'd0) begin
        s = 20'd1000000;
      end else if (tier == NOM_TIER) begin
        s = 20'd100000;
      end else if (tier == HALF_GAIN_TIER) begin
        s = 20'd2000;
      end else begin
        s = 20'd1000;
      end
      return s;
    end
  endfunction

endpackage

FILE: design/arm_in_if.sv
`timescale 1ns / 1ps

interface arm_in_if
  import arm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] diff_code;
  logic [CODE_W-1:0] sense_code;

  modport source (output valid, output diff_code, output sense_code, input ready);
  modport sink (input valid, input diff_code, input sense_code, output ready);
endinterface

FILE: design/arm_out_if.sv
`timescale 1ns / 1ps

interface arm_out_if
  import arm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic [RES_W-1:0]  resistance_milliohms;
  logic [TIER_W-1:0] tier_used;

  modport source (output valid, output status, output resistance_milliohms,
                  output tier_used, input ready);
  modport sink (input valid, input status, input resistance_milliohms,
                input tier_used, output ready);
endinterface

FILE: design/autorange_resistance_meter_core.sv
`timescale 1ns / 1ps

// Auto-ranging resistance meter core.
// The input channel takes one word per measurement: the signed ADC code of the
// voltage across the unknown resistor and the code across the sense resistor.
// The output channel gives one word per measurement: retry (with the tier
// stepped up or down for the next try) or done with the resistance in
// milliohms, and the tier that was in force.
// Configuration registers are written through cfg_wen/cfg_index/cfg_data; the
// user must write them only while the core is idle, as the core does not enforce it.
// A retry or a zero-voltage done skips the calculation. A nominal-current tier
// runs the multiplier only; a measured-current tier also runs the divider,
// unless the current is zero or the quotient saturates. A bit-serial shift-add
// multiplier runs 16 plus 20 steps and a restoring divider runs 40 steps, one
// bit per cycle.
// One measurement is in work at a time. A new word is taken as soon as the
// previous one has been handed to the output register, even while that result
// still waits. If the receiver stalls, a finished result holds in the
// calculation until the output register frees.
// Reset returns the tier to 0 and the registers to their defaults.

module autorange_resistance_meter_core
  import arm_pkg::*;
#(
  parameter int ADC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  arm_in_if.sink               in_ch,
  arm_out_if.source            out_ch
);

  localparam int SHIFT = ADC_BITS - 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_MUL_A  = 3'd2;
  localparam logic [2:0] ST_MUL_B  = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // Configuration registers.
  logic [CODE_W-1:0]  adc_offset;
  logic [THR_W-1:0]   low_threshold_code;
  logic [THR_W-1:0]   high_threshold_code;
  logic [REG16_W-1:0] vref_millivolts;
  logic [REG16_W-1:0] sense_ohms;

  logic [2:0]         state;
  logic [TIER_W-1:0]  cur_tier;
  logic [TIER_W-1:0]  tier;
  logic [CODE_W-1:0]  d_code;
  logic [CODE_W-1:0]  s_code;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  mcand;
  logic [SCALE_W-1:0] mplier;
  logic [CNT_W-1:0]   cnt;
  logic [CODE_W-1:0]  rem;
  logic               res_status;
  logic [RES_W-1:0]   res_value;

  logic               out_valid;
  logic               out_status;
  logic [RES_W-1:0]   out_res;
  logic [TIER_W-1:0]  out_tier;

  logic               in_fire;
  logic               out_load;
  logic [CODE_W:0]    diff_sub;
  logic [CODE_W:0]    sense_sub;
  logic [TIER_W-1:0]  tier_now;
  logic [PROD_W-1:0]  acc_sum;
  logic [PROD_W-1:0]  scaled;
  logic [CODE_W:0]    rem_sh;
  logic [CODE_W:0]    rem_diff;
  logic               rem_ge;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset          <= '0;
      low_threshold_code  <= 23'd167772;
      high_threshold_code <= 23'd7130317;
      vref_millivolts     <= 16'd5000;
      sense_ohms          <= 16'd330;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ADC_OFFSET: adc_offset          <= cfg_data[CODE_W-1:0];
        REG_LOW_THR:    low_threshold_code  <= cfg_data[THR_W-1:0];
        REG_HIGH_THR:   high_threshold_code <= cfg_data[THR_W-1:0];
        REG_VREF_MV:    vref_millivolts     <= cfg_data[REG16_W-1:0];
        REG_SENSE_OHMS: sense_ohms          <= cfg_data[REG16_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes and the offset subtraction at the input.
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state == ST_FINISH) && (!out_valid || out_ch.ready);

  assign diff_sub  = {in_ch.diff_code[CODE_W-1], in_ch.diff_code}
                   - {adc_offset[CODE_W-1], adc_offset};
  assign sense_sub = {in_ch.sense_code[CODE_W-1], in_ch.sense_code}
                   - {adc_offset[CODE_W-1], adc_offset};

  assign tier_now = (cur_tier > TOP_TIER) ? TOP_TIER : cur_tier;

  // Shared shift-add step, restoring divide step and the nominal-tier scaling.
  assign acc_sum  = mplier[0] ? (acc + mcand) : acc;
  assign scaled   = acc >> SHIFT;
  assign rem_sh   = {rem, acc[RES_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, s_code});
  assign rem_diff = rem_sh - {1'b0, s_code};

  // Measurement sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_tier <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            d_code <= diff_sub[CODE_W] ? '0 : diff_sub[CODE_W-1:0];
            s_code <= sense_sub[CODE_W] ? '0 : sense_sub[CODE_W-1:0];
            state  <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          tier      <= tier_now;
          res_value <= '0;
          if (d_code == '0 && tier_now < TOP_TIER) begin
            cur_tier   <= tier_now + 3'd1;
            res_status <= STATUS_RETRY;
            state      <= ST_FINISH;
          end else if (d_code == '0) begin
            cur_tier   <= '0;
            res_status <= STATUS_DONE;
            state      <= ST_FINISH;
          end else if (d_code < {1'b0, low_threshold_code} && tier_now < TOP_TIER) begin
            cur_tier   <= tier_now + 3'd1;
            res_status <= STATUS_RETRY;
            state      <= ST_FINISH;
          end else if (d_code > {1'b0, high_threshold_code} && tier_now > 3'd0) begin
            cur_tier   <= tier_now - 3'd1;
            res_status <= STATUS_RETRY;
            state      <= ST_FINISH;
          end else begin
            cur_tier   <= '0;
            res_status <= STATUS_DONE;
            acc        <= '0;
            mcand      <= {{(PROD_W-CODE_W){1'b0}}, d_code};
            mplier     <= {{(SCALE_W-REG16_W){1'b0}},
                           (tier_now <= NOM_TIER) ? vref_millivolts : sense_ohms};
            cnt        <= CNT_W'(MUL_A_STEPS - 1);
            state      <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          if (cnt == '0) begin
            mcand  <= acc_sum;
            acc    <= '0;
            mplier <= scale_of(tier);
            cnt    <= CNT_W'(MUL_B_STEPS - 1);
            state  <= ST_MUL_B;
          end else begin
            acc    <= acc_sum;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 1'b1;
          end
        end
        ST_MUL_B: begin
          acc    <= acc_sum;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (tier <= NOM_TIER) begin
            res_value <= (|scaled[PROD_W-1:RES_W]) ? RES_MAX : scaled[RES_W-1:0];
            state     <= ST_FINISH;
          end else if (s_code == '0) begin
            res_value <= '0;
            state     <= ST_FINISH;
          end else if ({{(CODE_W-QHI_W){1'b0}}, acc[PROD_W-1:RES_W]} >= s_code) begin
            // Quotient would not fit in 40 bits.
            res_value <= RES_MAX;
            state     <= ST_FINISH;
          end else begin
            rem   <= {{(CODE_W-QHI_W){1'b0}}, acc[PROD_W-1:RES_W]};
            cnt   <= CNT_W'(DIV_STEPS - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem             <= rem_ge ? rem_diff[CODE_W-1:0] : rem_sh[CODE_W-1:0];
          acc[RES_W-1:0]  <= {acc[RES_W-2:0], rem_ge};
          cnt             <= cnt - 1'b1;
          if (cnt == '0) begin
            res_value <= {acc[RES_W-2:0], rem_ge};
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_res    <= res_value;
      out_tier   <= tier;
    end
  end

  assign out_ch.valid                = out_valid;
  assign out_ch.status               = out_status;
  assign out_ch.resistance_milliohms = out_res;
  assign out_ch.tier_used            = out_tier;

  // Checks.
  a_tier_range: assert property (@(posedge clk) disable iff (rst)
    cur_tier <= TOP_TIER)
    else $error("tier register left its range");

  a_retry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == STATUS_RETRY) |-> out_ch.resistance_milliohms == '0)
    else $error("retry word carries a resistance");

  a_done_resets_tier: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_status == STATUS_DONE) |-> cur_tier == '0)
    else $error("tier not returned to zero after a done result");

  a_tier_used_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.tier_used <= TOP_TIER)
    else $error("reported tier out of range");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import arm_pkg::*;

  localparam int ADC_BITS = 24;
  localparam longint CODE_MAX = 8388607;
  localparam longint CODE_MIN = -8388608;
  localparam int PHASE_ITEMS = 253;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_CAP = 60;

  localparam logic [CFG_IDX_W-1:0] REG_LIST [5] = '{REG_ADC_OFFSET, REG_LOW_THR,
                                                    REG_HIGH_THR, REG_VREF_MV,
                                                    REG_SENSE_OHMS};

  typedef struct packed {
    logic              status;
    logic [RES_W-1:0]  resistance_milliohms;
    logic [TIER_W-1:0] tier_used;
  } reading_t;

  typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    bit                typed;
    reading_t          want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  arm_in_if  in_ch ();
  arm_out_if out_ch ();

  autorange_resistance_meter_core #(
    .ADC_BITS(ADC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Mirror of the meter's registers and range state.
  logic [CODE_W-1:0]  m_offset;
  logic [THR_W-1:0]   m_low;
  logic [THR_W-1:0]   m_high;
  logic [REG16_W-1:0] m_vref;
  logic [REG16_W-1:0] m_sense;
  logic [TIER_W-1:0]  m_tier;

  reading_t pending_readings [$];
  plan_row_t plan [$];

  int mismatches = 0;
  int words_checked = 0;
  int items_sent = 0;
  int retry_words = 0;
  int done_by_tier [5] = '{0, 0, 0, 0, 0};
  int settings_used = 0;

  int send_idle_pct = 10;
  int recv_stall_pct = 55;
  bit long_hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offset removal with clipping of negative codes to zero.
  function automatic logic [CODE_W-1:0] clip_code(input logic [CODE_W-1:0] raw);
    logic signed [CODE_W:0] delta;
    delta = $signed({raw[CODE_W-1], raw}) - $signed({m_offset[CODE_W-1], m_offset});
    return delta[CODE_W] ? '0 : delta[CODE_W-1:0];
  endfunction

  // Expected reading for one measurement; also steps the tier.
  function automatic reading_t predict_reading(input logic [CODE_W-1:0] diff_raw,
                                               input logic [CODE_W-1:0] sense_raw);
    logic [CODE_W-1:0] d;
    logic [CODE_W-1:0] s;
    logic [TIER_W-1:0] tier;
    logic [63:0] product;
    logic [63:0] quotient;
    logic step_up;
    logic step_down;
    reading_t r;
    tier = (m_tier > TOP_TIER) ? TOP_TIER : m_tier;
    d = clip_code(diff_raw);
    s = clip_code(sense_raw);
    step_up = 1'b0;
    step_down = 1'b0;
    quotient = '0;
    if (d == '0) begin
      // At the top tier a zero reading completes with zero resistance.
      step_up = (tier < TOP_TIER);
    end else if (d < m_low && tier < TOP_TIER) begin
      step_up = 1'b1;
    end else if (d > m_high && tier != '0) begin
      step_down = 1'b1;
    end else if (tier <= NOM_TIER) begin
      product = 64'(d) * 64'(m_vref) * ((tier == '0) ? 64'd1000000 : 64'd100000);
      quotient = product >> (ADC_BITS - 1);
    end else if (s != '0) begin
      product = 64'(d) * 64'(m_sense) * ((tier == HALF_GAIN_TIER) ? 64'd2000 : 64'd1000);
      quotient = product / 64'(s);
    end
    if (step_up) begin
      m_tier = tier + 1'b1;
    end else if (step_down) begin
      m_tier = tier - 1'b1;
    end else begin
      m_tier = '0;
    end
    r.status = (step_up || step_down) ? STATUS_RETRY : STATUS_DONE;
    r.resistance_milliohms = (quotient > 64'(RES_MAX)) ? RES_MAX : quotient[RES_W-1:0];
    r.tier_used = tier;
    return r;
  endfunction

  function automatic plan_row_t meas(input logic [CODE_W-1:0] d, input logic [CODE_W-1:0] s);
    plan_row_t row;
    row.kind = ROW_MEAS;
    row.a = d;
    row.b = s;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t meas_exp(input logic [CODE_W-1:0] d,
                                         input logic [CODE_W-1:0] s,
                                         input logic st, input logic [RES_W-1:0] res,
                                         input logic [TIER_W-1:0] tier);
    plan_row_t row;
    row = meas(d, s);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.resistance_milliohms = res;
    row.want.tier_used = tier;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = meas(CODE_W'(idx), val);
    row.kind = ROW_CFG;
    return row;
  endfunction

  // Raw code whose clipped value is the requested amount, within code range.
  function automatic logic [CODE_W-1:0] code_for(input longint amount);
    longint v;
    v = longint'($signed(m_offset)) + amount;
    if (v > CODE_MAX) v = CODE_MAX;
    if (v < CODE_MIN) v = CODE_MIN;
    return v[CODE_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] low_code();
    if ($urandom_range(7) == 0) return code_for(-longint'($urandom_range(1000)));
    if (m_low == '0) return code_for(0);
    return code_for($urandom_range(m_low - 1, 0));
  endfunction

  function automatic logic [CODE_W-1:0] sense_code();
    case ($urandom_range(9))
      0: return code_for(-longint'($urandom_range(50)));
      1, 2: return code_for($urandom_range(2000, 1));
      3: return CODE_W'($urandom);
      default: return code_for($urandom_range(CODE_MAX, 1));
    endcase
  endfunction

  task automatic check_field(input string field, input logic [RES_W-1:0] want,
                             input logic [RES_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  // Register write through the plain write port, then a wait with cfg_wen low.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ADC_OFFSET: m_offset = val[CODE_W-1:0];
      REG_LOW_THR:    m_low = val[THR_W-1:0];
      REG_HIGH_THR:   m_high = val[THR_W-1:0];
      REG_VREF_MV:    m_vref = val[REG16_W-1:0];
      REG_SENSE_OHMS: m_sense = val[REG16_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one measurement word and record its expected reading on acceptance.
  task automatic send_meas(input logic [CODE_W-1:0] d, input logic [CODE_W-1:0] s,
                           input bit typed, input reading_t want);
    reading_t got;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.diff_code <= d;
    in_ch.sense_code <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = predict_reading(d, s);
    pending_readings.push_back(typed ? want : got);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering words and wait until every reading has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Mostly a walk up through the tiers ending in an in-range reading; the
  // rest are over-range readings and unshaped noise.
  task automatic run_sequence();
    int pick;
    int steps;
    pick = $urandom_range(99);
    if (pick < 70) begin
      steps = $urandom_range(TOP_TIER);
      repeat (steps) send_meas(low_code(), sense_code(), 1'b0, '0);
      send_meas(code_for($urandom_range(m_high, m_low)), sense_code(), 1'b0, '0);
    end else if (pick < 85) begin
      send_meas(code_for($urandom_range(24'hFFFFFF, m_high + 1)), sense_code(), 1'b0, '0);
    end else begin
      send_meas(CODE_W'($urandom), CODE_W'($urandom), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (long_hold_req && !hold_taken) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expected reading.
  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got status %0d res %0d tier %0d",
                 $time, out_ch.status, out_ch.resistance_milliohms, out_ch.tier_used);
      end else begin
        want = pending_readings.pop_front();
        words_checked++;
        check_field("status", RES_W'(want.status), RES_W'(out_ch.status));
        check_field("resistance_milliohms", want.resistance_milliohms,
                    out_ch.resistance_milliohms);
        check_field("tier_used", RES_W'(want.tier_used), RES_W'(out_ch.tier_used));
        if (want.status == STATUS_DONE && want.tier_used <= TOP_TIER) begin
          done_by_tier[want.tier_used]++;
        end else begin
          retry_words++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d readings outstanding",
               $time, stall_cycles, pending_readings.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] vals [5];
    int start;
    bit paused;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = REG_ADC_OFFSET;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.diff_code = '0;
    in_ch.sense_code = '0;
    out_ch.ready = 1'b0;
    m_offset = '0;
    m_low = 23'd167772;
    m_high = 23'd7130317;
    m_vref = 16'd5000;
    m_sense = 16'd330;
    m_tier = '0;

    // Reset values: zero, clipped and below-threshold readings walk the tier to the top.
    plan.push_back(meas_exp(24'd0, 24'd0, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas_exp(24'h800000, 24'h800000, STATUS_RETRY, '0, 3'd1));
    plan.push_back(meas_exp(24'd167771, 24'd7, STATUS_RETRY, '0, 3'd2));
    plan.push_back(meas_exp(24'd1, 24'd0, STATUS_RETRY, '0, 3'd3));
    // Zero voltage at the top tier completes with zero.
    plan.push_back(meas_exp(24'd0, 24'h7FFFFF, STATUS_DONE, '0, TOP_TIER));
    // Over-range at the bottom tier still completes.
    plan.push_back(meas(24'h7FFFFF, 24'h7FFFFF));
    plan.push_back(meas_exp(24'h400000, 24'd0, STATUS_DONE, 40'd2500000000, 3'd0));
    plan.push_back(meas_exp(24'd100, 24'd5, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas(24'd1000000, 24'h123456));
    // Zero measured current at a measured-current tier.
    plan.push_back(meas_exp(24'd1, 24'd0, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas_exp(24'd2, 24'd0, STATUS_RETRY, '0, 3'd1));
    plan.push_back(meas_exp(24'd1000000, 24'hFFFFFB, STATUS_DONE, '0, 3'd2));
    // Step down from tier 1, then saturate at tier 3.
    plan.push_back(meas_exp(24'd3, 24'd0, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas_exp(24'h7FFFFF, 24'd1, STATUS_RETRY, '0, 3'd1));
    plan.push_back(meas_exp(24'd3, 24'd0, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas_exp(24'd3, 24'd0, STATUS_RETRY, '0, 3'd1));
    plan.push_back(meas_exp(24'd3, 24'd0, STATUS_RETRY, '0, 3'd2));
    plan.push_back(meas_exp(24'd4000000, 24'd1, STATUS_DONE, RES_MAX, 3'd3));
    // Over-range and under-range at the top tier.
    plan.push_back(meas_exp(24'd4, 24'd0, STATUS_RETRY, '0, 3'd0));
    plan.push_back(meas_exp(24'd4, 24'd0, STATUS_RETRY, '0, 3'd1));
    plan.push_back(meas_exp(24'd4, 24'd0, STATUS_RETRY, '0, 3'd2));
    plan.push_back(meas_exp(24'd4, 24'd0, STATUS_RETRY, '0, 3'd3));
    plan.push_back(meas_exp(24'h7FFFFF, 24'd9, STATUS_RETRY, '0, TOP_TIER));
    plan.push_back(meas_exp(24'd1, 24'h800000, STATUS_RETRY, '0, 3'd3));
    plan.push_back(meas(24'd1, 24'h7FFFFF));
    // Offset extremes.
    plan.push_back(cfg_row(REG_ADC_OFFSET, 24'h7FFFFF));
    plan.push_back(meas_exp(24'h7FFFFF, 24'h7FFFFF, STATUS_RETRY, '0, 3'd0));
    plan.push_back(cfg_row(REG_ADC_OFFSET, 24'h800000));
    plan.push_back(meas(24'h7FFFFF, 24'h7FFFFF));
    plan.push_back(meas(24'h7FFFFF, 24'h000000));
    // Zero reference gives zero resistance at tier 0; the sense resistor is also set to zero.
    plan.push_back(cfg_row(REG_ADC_OFFSET, 24'd0));
    plan.push_back(cfg_row(REG_VREF_MV, 24'd0));
    plan.push_back(cfg_row(REG_SENSE_OHMS, 24'd0));
    plan.push_back(meas_exp(24'h400000, 24'd5, STATUS_DONE, '0, 3'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_cfg(plan[i].a[CFG_IDX_W-1:0], plan[i].b);
      end else begin
        send_meas(plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting; the idling mix changes every two phases.
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p < 2) begin
        send_idle_pct = 10;
        recv_stall_pct = 55;
      end else if (p < 4) begin
        send_idle_pct = 55;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      vals[0] = CFG_W'(int'($urandom_range(400000)) - 200000);
      vals[3] = CFG_W'($urandom_range(65535, 1));
      vals[4] = CFG_W'($urandom_range(65535, 1));
      case (p)
        0: begin
          vals = '{24'd0, 24'd167772, 24'd7130317, 24'd5000, 24'd330};
        end
        1: begin
          vals[1] = CFG_W'($urandom_range(400000));
          vals[2] = CFG_W'($urandom_range(8388607, 4000000));
          vals[3] = 24'd65535;
          vals[4] = 24'd65535;
        end
        2: begin
          vals = '{24'h800000, 24'd0, 24'h7FFFFF, 24'd1, 24'd1};
        end
        3: begin
          vals[1] = 24'h7FFFFF;
          vals[2] = 24'h7FFFFF;
          vals[4] = 24'd0;
        end
        4: begin
          vals[1] = CFG_W'($urandom_range(2000000));
          vals[2] = CFG_W'($urandom_range(8388607, vals[1]));
        end
        default: begin
          vals[1] = 24'd0;
          vals[2] = 24'd0;
        end
      endcase
      foreach (REG_LIST[i]) write_cfg(REG_LIST[i], vals[i]);
      settings_used++;
      if (p == 0) long_hold_req = 1'b1;
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < PHASE_ITEMS) begin
        if (p == 4 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        run_sequence();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d measurements (%0d directed rows) across %0d random register settings,",
             items_sent, plan.size(), settings_used);
    $display("%0d words checked: %0d retries, completed by tier %0d/%0d/%0d/%0d/%0d.",
             words_checked, retry_words, done_by_tier[0], done_by_tier[1], done_by_tier[2],
             done_by_tier[3], done_by_tier[4]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
